/* rtl/lse_pkg.sv */
package lse_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_NORMAL  = 2'd0;
    localparam status_t ST_NAN     = 2'd1;
    localparam status_t ST_NEG_INF = 2'd2;

    // element count field of a close command, wide enough for the largest set
    localparam int CNT_W = 17;

    localparam logic signed [33:0] L2E_Q32    = 34'sd6196328019;
    localparam logic signed [33:0] LN2_HI_Q30 = 34'sd744259584;
    localparam logic signed [33:0] LN2_LO_Q30 = 34'sd1534;
    localparam logic signed [33:0] LN2_Q30    = 34'sd744261118;
    localparam logic signed [32:0] CLAMP_Q16  = -33'sd45875200;
    localparam logic signed [33:0] Q30_ONE    = 34'sd1073741824;
    localparam logic signed [33:0] T_INIT     = 34'sd119304647;
    localparam logic [47:0]        SUM_MAX    = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] max_val;
        logic [CNT_W-1:0]   count;
        status_t            status;
    } lse_cmd_t;

    // Horner coefficients 1/n! in Q30, highest order first
    function automatic logic signed [33:0] exp_coef(input logic [3:0] idx);
        logic signed [33:0] c;
        case (idx)
            4'd0:    c = 34'sd27;
            4'd1:    c = 34'sd296;
            4'd2:    c = 34'sd2959;
            4'd3:    c = 34'sd26631;
            4'd4:    c = 34'sd213044;
            4'd5:    c = 34'sd1491308;
            4'd6:    c = 34'sd8947849;
            4'd7:    c = 34'sd44739243;
            4'd8:    c = 34'sd178956971;
            4'd9:    c = 34'sd536870912;
            default: c = Q30_ONE;
        endcase
        return c;
    endfunction

    // odd series 1/7, 1/5, 1/3 and 1 in Q30, after the initial 1/9 term
    function automatic logic signed [33:0] ln_coef(input logic [3:0] idx);
        logic signed [33:0] c;
        case (idx)
            4'd1:    c = 34'sd153391689;
            4'd2:    c = 34'sd214748365;
            4'd3:    c = 34'sd357913941;
            default: c = Q30_ONE;
        endcase
        return c;
    endfunction

endpackage

/* rtl/lse_ifs.sv */
interface lse_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               is_nan;
    logic               is_neg_inf;
    logic               no_element;
    logic               last;

    modport source (output valid, value, is_nan, is_neg_inf, no_element, last, input ready);
    modport sink   (input valid, value, is_nan, is_neg_inf, no_element, last, output ready);
endinterface

interface lse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic [1:0]         status;

    modport source (output valid, result, status, input ready);
    modport sink   (input valid, result, status, output ready);
endinterface

/* rtl/lse_ram.sv */
module lse_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lse_front.sv */
module lse_front import lse_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    lse_in_if.sink          in_ch,
    input  logic            back_busy,
    output logic            wr_en,
    output logic [AW-1:0]   wr_addr,
    output logic [32:0]     wr_data,
    output lse_cmd_t        cmd,
    output logic            cmd_valid,
    input  logic            cmd_take
);

    logic signed [31:0] max_reg, max_next;
    logic               fin_reg, fin_next;
    logic               nan_reg, nan_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    lse_cmd_t           cmd_reg;
    logic               cmd_valid_reg;
    logic               accept;
    logic               store;
    status_t            close_status;

    // hold off beats while a set is queued or being reduced: the store is shared
    assign in_ch.ready = !cmd_valid_reg && !back_busy;
    assign accept      = in_ch.valid && in_ch.ready;
    assign store       = accept && !in_ch.no_element && (cnt_reg < CW'(MAX_ELEMENTS));

    assign wr_en   = store;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = {in_ch.is_nan || in_ch.is_neg_inf, in_ch.value};

    always_comb
    begin
        max_next = max_reg;
        fin_next = fin_reg;
        nan_next = nan_reg;
        cnt_next = cnt_reg;
        if (store)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (in_ch.is_nan)
            begin
                nan_next = 1'b1;
            end
            else if (!in_ch.is_neg_inf && (!fin_reg || in_ch.value > max_reg))
            begin
                max_next = in_ch.value;
                fin_next = 1'b1;
            end
        end
        if (nan_next)
        begin
            close_status = ST_NAN;
        end
        else if (!fin_next)
        begin
            close_status = ST_NEG_INF;
        end
        else
        begin
            close_status = ST_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= 32'sh8000_0000;
            fin_reg       <= 1'b0;
            nan_reg       <= 1'b0;
            cnt_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (accept && in_ch.last)
            begin
                cmd_valid_reg <= 1'b1;
                max_reg       <= 32'sh8000_0000;
                fin_reg       <= 1'b0;
                nan_reg       <= 1'b0;
                cnt_reg       <= '0;
            end
            else
            begin
                max_reg <= max_next;
                fin_reg <= fin_next;
                nan_reg <= nan_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.last)
        begin
            cmd_reg.max_val <= max_next;
            cmd_reg.count   <= CNT_W'(cnt_next);
            cmd_reg.status  <= close_status;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = cmd_valid_reg;

endmodule

/* rtl/lse_back.sv */
module lse_back import lse_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lse_cmd_t      cmd,
    input  logic          cmd_valid,
    output logic          cmd_take,
    output logic          busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [32:0]   rd_data,
    lse_out_if.source     out_ch
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_RDW  = 5'd2;
    localparam logic [4:0] S_KM   = 5'd3;
    localparam logic [4:0] S_K    = 5'd4;
    localparam logic [4:0] S_HM   = 5'd5;
    localparam logic [4:0] S_H    = 5'd6;
    localparam logic [4:0] S_LM   = 5'd7;
    localparam logic [4:0] S_L    = 5'd8;
    localparam logic [4:0] S_PM   = 5'd9;
    localparam logic [4:0] S_P    = 5'd10;
    localparam logic [4:0] S_SH   = 5'd11;
    localparam logic [4:0] S_LN0  = 5'd12;
    localparam logic [4:0] S_NORM = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_U2M  = 5'd15;
    localparam logic [4:0] S_U2   = 5'd16;
    localparam logic [4:0] S_TM   = 5'd17;
    localparam logic [4:0] S_T    = 5'd18;
    localparam logic [4:0] S_UTM  = 5'd19;
    localparam logic [4:0] S_UT   = 5'd20;
    localparam logic [4:0] S_MLM  = 5'd21;
    localparam logic [4:0] S_ML   = 5'd22;
    localparam logic [4:0] S_DONE = 5'd23;

    logic [4:0]         state_reg;
    logic signed [31:0] max_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      idx_reg;
    logic signed [33:0] d_reg;
    logic signed [11:0] k_reg;
    logic signed [41:0] r_reg;
    logic signed [33:0] p_reg;
    logic [3:0]         i_reg;
    logic [47:0]        sum_reg;
    logic [47:0]        n_reg;
    logic [5:0]         m_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        div_reg;
    logic [29:0]        u_reg;
    logic [4:0]         step_reg;
    logic signed [33:0] u2_reg;
    logic signed [33:0] t_reg;
    logic signed [33:0] w_reg;
    logic signed [67:0] prod_reg;
    logic signed [31:0] res_reg;
    status_t            st_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_result_reg;
    status_t            out_status_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_rnd;
    logic signed [33:0] rnd30;
    logic               last_idx;
    logic signed [32:0] diff;
    logic [11:0]        s_val;
    logic [63:0]        half;
    logic [63:0]        e_val;
    logic [48:0]        sum_wide;
    logic [33:0]        rem_sh;
    logic [30:0]        mant;
    logic signed [39:0] ln_val;
    logic signed [39:0] ln_rnd;
    logic signed [33:0] total;
    logic               load_out;

    assign busy     = (state_reg != S_IDLE);
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign rd_en    = (state_reg == S_RD);
    assign rd_addr  = idx_reg[AW-1:0];
    assign last_idx = (idx_reg + 1'b1) == cnt_reg;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    // round a Q30 product to nearest, ties up
    assign prod_rnd = (prod_reg + 68'sd536870912) >>> 30;
    assign rnd30    = prod_rnd[33:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_KM:
            begin
                mul_a = d_reg;
                mul_b = L2E_Q32;
            end
            S_HM:
            begin
                mul_a = 34'(k_reg);
                mul_b = LN2_HI_Q30;
            end
            S_LM:
            begin
                mul_a = 34'(k_reg);
                mul_b = LN2_LO_Q30;
            end
            S_PM:
            begin
                mul_a = p_reg;
                mul_b = r_reg[33:0];
            end
            S_U2M:
            begin
                mul_a = $signed({4'b0, u_reg});
                mul_b = $signed({4'b0, u_reg});
            end
            S_TM:
            begin
                mul_a = t_reg;
                mul_b = u2_reg;
            end
            S_UTM:
            begin
                mul_a = $signed({4'b0, u_reg});
                mul_b = t_reg;
            end
            S_MLM:
            begin
                mul_a = $signed({28'b0, m_reg}) - 34'sd30;
                mul_b = LN2_Q30;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        diff = $signed({rd_data[31], rd_data[31:0]}) - $signed({max_reg[31], max_reg});
        if (diff < CLAMP_Q16)
        begin
            diff = CLAMP_Q16;
        end
        else if (diff > 33'sd0)
        begin
            diff = '0;
        end

        s_val = 12'(-k_reg);
        half  = (s_val == 12'd0) ? 64'd0 : (64'd1 << (s_val[5:0] - 6'd1));
        if (p_reg <= 34'sd0 || s_val >= 12'd62)
        begin
            e_val = '0;
        end
        else
        begin
            e_val = ({30'b0, p_reg} + half) >> s_val[5:0];
        end
        sum_wide = {1'b0, sum_reg} + e_val[48:0];

        rem_sh = {rem_reg[32:0], 1'b0};
        mant   = n_reg[47:17];

        ln_val = 40'(prod_reg) + 40'(w_reg) + 40'(w_reg);
        ln_rnd = (ln_val + 40'sd8192) >>> 14;
        total  = 34'(max_reg) + 34'(ln_rnd);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                max_reg <= cmd.max_val;
                cnt_reg <= cmd.count[CW-1:0];
                idx_reg <= '0;
                sum_reg <= '0;
                st_reg  <= cmd.status;
                res_reg <= '0;
            end
            S_RDW:
            begin
                d_reg <= 34'(diff);
                if (rd_data[32])
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_K:
            begin
                k_reg <= 12'((prod_reg + 68'sh8000_0000_0000) >>> 48);
                r_reg <= 42'(d_reg) <<< 14;
            end
            S_H:
            begin
                r_reg <= r_reg - prod_reg[41:0];
            end
            S_L:
            begin
                r_reg <= r_reg - prod_reg[41:0];
                p_reg <= exp_coef(4'd0);
                i_reg <= 4'd1;
            end
            S_P:
            begin
                p_reg <= rnd30 + exp_coef(i_reg);
                i_reg <= i_reg + 4'd1;
            end
            S_SH:
            begin
                sum_reg <= sum_wide[48] ? SUM_MAX : sum_wide[47:0];
                idx_reg <= idx_reg + 1'b1;
            end
            S_LN0:
            begin
                n_reg <= sum_reg;
                m_reg <= 6'd47;
                if (sum_reg == '0)
                begin
                    st_reg <= ST_NEG_INF;
                end
            end
            S_NORM:
            begin
                if (!n_reg[47])
                begin
                    n_reg <= {n_reg[46:0], 1'b0};
                    m_reg <= m_reg - 6'd1;
                end
                rem_reg  <= {3'b0, mant} - 34'd1073741824;
                div_reg  <= {1'b0, mant} + 32'd1073741824;
                step_reg <= '0;
            end
            S_DIV:
            begin
                if (rem_sh >= {2'b0, div_reg})
                begin
                    rem_reg <= rem_sh - {2'b0, div_reg};
                    u_reg   <= {u_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    u_reg   <= {u_reg[28:0], 1'b0};
                end
                step_reg <= step_reg + 5'd1;
            end
            S_U2:
            begin
                u2_reg <= rnd30;
                t_reg  <= T_INIT;
                i_reg  <= 4'd1;
            end
            S_T:
            begin
                t_reg <= rnd30 + ln_coef(i_reg);
                i_reg <= i_reg + 4'd1;
            end
            S_UT:
            begin
                w_reg <= rnd30;
            end
            S_ML:
            begin
                if (total > 34'sd2147483647)
                begin
                    res_reg <= 32'sh7FFF_FFFF;
                end
                else if (total < -34'sd2147483648)
                begin
                    res_reg <= 32'sh8000_0000;
                end
                else
                begin
                    res_reg <= total[31:0];
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_result_reg <= (st_reg == ST_NORMAL) ? res_reg : 32'sd0;
            out_status_reg <= st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= (cmd.status == ST_NORMAL) ? S_RD : S_DONE;
                    end
                end
                S_RD:   state_reg <= S_RDW;
                S_RDW:
                begin
                    if (rd_data[32])
                    begin
                        state_reg <= last_idx ? S_LN0 : S_RD;
                    end
                    else
                    begin
                        state_reg <= S_KM;
                    end
                end
                S_KM:   state_reg <= S_K;
                S_K:    state_reg <= S_HM;
                S_HM:   state_reg <= S_H;
                S_H:    state_reg <= S_LM;
                S_LM:   state_reg <= S_L;
                S_L:    state_reg <= S_PM;
                S_PM:   state_reg <= S_P;
                S_P:    state_reg <= (i_reg == 4'd11) ? S_SH : S_PM;
                S_SH:   state_reg <= last_idx ? S_LN0 : S_RD;
                S_LN0:  state_reg <= (sum_reg == '0) ? S_DONE : S_NORM;
                S_NORM: state_reg <= n_reg[47] ? S_DIV : S_NORM;
                S_DIV:  state_reg <= (step_reg == 5'd29) ? S_U2M : S_DIV;
                S_U2M:  state_reg <= S_U2;
                S_U2:   state_reg <= S_TM;
                S_TM:   state_reg <= S_T;
                S_T:    state_reg <= (i_reg == 4'd4) ? S_UTM : S_TM;
                S_UTM:  state_reg <= S_UT;
                S_UT:   state_reg <= S_MLM;
                S_MLM:  state_reg <= S_ML;
                S_ML:   state_reg <= S_DONE;
                S_DONE: state_reg <= load_out ? S_IDLE : S_DONE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.result = out_result_reg;
    assign out_ch.status = out_status_reg;

endmodule

/* rtl/log_sum_exp_reduction.sv */
// Log-sum-exp over a set of signed Q16.16 elements, at most one per input beat;
// the beat marked last closes the set and one result beat (value and status)
// follows. The front end takes one beat per cycle, writes each element into a
// single-port-write, registered-read store of MAX_ELEMENTS entries and tracks
// the running maximum and NaN flag. On the closing beat it queues a command for
// the back end and refuses further beats until that set has been reduced,
// since both ends share the store. The back end walks the stored elements
// through one shared 34x34 multiplier: a minus-infinity element is read and
// skipped, any other element passes through read, range reduction, eleven
// Horner steps, scale and accumulate. The logarithm then normalises the sum,
// divides bit-serially and evaluates a series. A set that is NaN, empty or
// only minus infinity skips the reduction and is answered directly.
// The result sits in an output register, so the next set may start as soon as
// the result is loaded. No clearing pass is needed after reset.
module log_sum_exp_reduction import lse_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    lse_in_if.sink    in_ch,
    lse_out_if.source out_ch
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [32:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [32:0]   rd_data;
    lse_cmd_t      cmd;
    logic          cmd_valid;
    logic          cmd_take;
    logic          back_busy;

    // classify and store beats; hand over the closed set
    lse_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .back_busy (back_busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    // element store: value plus a skip mark for minus infinity or NaN
    lse_ram #(.WIDTH(33), .DEPTH(MAX_ELEMENTS)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // exp-sum pass, logarithm and result register
    lse_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .busy      (back_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_ch    (out_ch)
    );

endmodule

/* dv/testbench.sv */
// Checks log_sum_exp_reduction with its own fixed-point copy of the arithmetic.
class lse_scoreboard;
    typedef struct {
        logic signed [31:0]  result;
        lse_pkg::status_t    status;
    } lse_answer_t;

    int                   errors;
    lse_answer_t          answers[$];
    logic signed [31:0]   elems[1024];
    bit                   dead[1024];
    logic signed [31:0]   run_max;
    bit                   max_ok;
    bit                   saw_nan;
    int                   count;
    longint               coef[12] = '{27, 296, 2959, 26631, 213044, 1491308, 8947849,
                                       44739243, 178956971, 536870912,
                                       1073741824, 1073741824};

    function new();
        errors = 0;
        clear_set();
    endfunction

    function void clear_set();
        run_max = 32'sh8000_0000;
        max_ok  = 0;
        saw_nan = 0;
        count   = 0;
    endfunction

    // round-to-nearest Q30 product, ties upward
    function longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint exp_q30(longint d);
        longint k, r, p;
        int     s;
        if (d < -64'sd45875200) d = -64'sd45875200;
        if (d > 0) d = 0;
        k = (d * 64'sd6196328019 + (64'sd1 <<< 47)) >>> 48;
        r = d * 16384 - k * 64'sd744259584 - k * 64'sd1534;
        p = coef[0];
        for (int i = 1; i < 12; i++)
            p = mul_q30(p, r) + coef[i];
        if (p <= 0) return 0;
        s = int'(-k);
        if (s >= 62) return 0;
        if (s == 0) return p;
        return (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint ln_q30(longint x);
        int     m;
        longint mant, u, u2, t;
        m = 63;
        while (m > 0 && x[m] == 1'b0) m--;
        if (m >= 30) mant = x >>> (m - 30);
        else         mant = x <<< (30 - m);
        u  = ((mant - 64'sd1073741824) * 64'sd1073741824) / (mant + 64'sd1073741824);
        u2 = mul_q30(u, u);
        t  = 119304647;
        t  = mul_q30(t, u2) + 153391689;
        t  = mul_q30(t, u2) + 214748365;
        t  = mul_q30(t, u2) + 357913941;
        t  = mul_q30(t, u2) + 64'sd1073741824;
        return longint'(m - 30) * 64'sd744261118 + 2 * mul_q30(u, t);
    endfunction

    // note an accepted input beat; a closing beat queues one answer
    function void note_beat(logic signed [31:0] v, bit nan, bit ninf, bit none, bit last);
        lse_answer_t a;
        longint      sum, res;
        if (!none && count < 1024) begin
            elems[count] = v;
            dead[count]  = ninf || nan;
            count++;
            if (nan) saw_nan = 1;
            else if (!ninf && (!max_ok || v > run_max)) begin
                run_max = v;
                max_ok  = 1;
            end
        end
        if (!last) return;
        a.result = 0;
        if (saw_nan) a.status = lse_pkg::ST_NAN;
        else if (!max_ok) a.status = lse_pkg::ST_NEG_INF;
        else begin
            sum = 0;
            for (int i = 0; i < count; i++)
                if (!dead[i]) begin
                    sum += exp_q30(longint'(elems[i]) - longint'(run_max));
                    if (sum > 64'sh0000_FFFF_FFFF_FFFF) sum = 64'sh0000_FFFF_FFFF_FFFF;
                end
            if (sum == 0) a.status = lse_pkg::ST_NEG_INF;
            else begin
                a.status = lse_pkg::ST_NORMAL;
                res = longint'(run_max) + ((ln_q30(sum) + 8192) >>> 14);
                if (res > 64'sd2147483647) res = 64'sd2147483647;
                if (res < -64'sd2147483648) res = -64'sd2147483648;
                a.result = res[31:0];
            end
        end
        answers.push_back(a);
        clear_set();
    endfunction

    function void check_beat(logic signed [31:0] res, logic [1:0] st);
        lse_answer_t a;
        if (answers.size() == 0) begin
            $error("unexpected result beat: result %0d status %0d", res, st);
            errors++;
            return;
        end
        a = answers.pop_front();
        if (st !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, st);
            errors++;
        end
        if (res !== a.result) begin
            $error("result: expected %0d, got %0d", a.result, res);
            errors++;
        end
    endfunction
endclass

module testbench;
    import lse_pkg::*;

    logic clk;
    logic rst_n;
    int   idle_pct;     // chance per cycle that the sender holds off
    int   stall_pct;    // chance per cycle that the receiver holds ready low
    int   quiet_cycles;
    int   beats_sent;

    lse_in_if  in_ch();
    lse_out_if out_ch();
    lse_scoreboard sb;

    log_sum_exp_reduction dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Drive one input beat and hold it until the block takes it. Idle gaps go
    // in front of the beat, so valid only drops between beats.
    task automatic send_beat(logic signed [31:0] v, bit nan, bit ninf, bit none, bit last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            in_ch.value <= $urandom;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.is_nan     <= nan;
        in_ch.is_neg_inf <= ninf;
        in_ch.no_element <= none;
        in_ch.last       <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_beat(v, nan, ninf, none, last);
        beats_sent++;
    endtask

    // Pick an element near base: mostly small spreads, now and then wide ones
    // that run into the exp clamp.
    function automatic logic signed [31:0] near(logic signed [31:0] base);
        longint v;
        int     span;
        span = $urandom_range(26);
        v = longint'(base) - longint'($urandom_range((1 << span) - 1));
        if ($urandom_range(9) == 0) v = longint'(base) + $urandom_range(1 << span);
        if ($urandom_range(19) == 0) v = $signed($urandom);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // One set with random content: mostly finite elements, a sprinkling of
    // minus infinity, NaN and element-less filler beats; closing beat may carry
    // an element or none.
    task automatic send_set(int n);
        logic signed [31:0] base;
        int                 kind;
        base = $urandom_range(1) ? $signed($urandom) : $signed($urandom_range(1 << 22))
               - $signed(32'd1 << 21);
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 6)       send_beat($urandom, 0, 1, 0, 0);
            else if (kind < 8)  send_beat($urandom, 1, 1'($urandom_range(1)), 0, 0);
            else if (kind < 12) send_beat($urandom, 1'($urandom), 1'($urandom), 1, 0);
            else                send_beat(near(base), 0, 0, 0, 0);
        end
        if ($urandom_range(3) == 0) send_beat($urandom, 1'($urandom), 1'($urandom), 1, 1);
        else if ($urandom_range(49) == 0) send_beat($urandom, 1, 0, 0, 1);
        else send_beat(near(base), 0, $urandom_range(19) == 0, 0, 1);
    endtask

    // Receiver: check each result beat, then decide ready for the next cycle.
    // Also run the watchdog on cycles where neither side moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_beat(out_ch.result, out_ch.status);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 200000)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        sb = new();
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        beats_sent   = 0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.is_nan     = 1'b0;
        in_ch.is_neg_inf = 1'b0;
        in_ch.no_element = 1'b0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set: a lone closing beat with no element
        send_beat(0, 0, 0, 1, 1);
        // single elements at both extremes and zero
        send_beat(32'sh7FFF_FFFF, 0, 0, 0, 1);
        send_beat(32'sh8000_0000, 0, 0, 0, 1);
        send_beat(0, 0, 0, 0, 1);
        // two equal maxima at the top: ln2 pushes past the range, saturate
        send_beat(32'sh7FFF_FFFF, 0, 0, 0, 0);
        send_beat(32'sh7FFF_FFFF, 0, 0, 0, 1);
        // two equal minima, plus a far element under the exp clamp
        send_beat(32'sh8000_0000, 0, 0, 0, 0);
        send_beat(32'sh8000_0000, 0, 0, 0, 1);
        send_beat(32'sh7FFF_FFFF, 0, 0, 0, 0);
        send_beat(32'sh8000_0000, 0, 0, 0, 1);
        // only minus infinity
        send_beat(32'sh1234_5678, 0, 1, 0, 0);
        send_beat(-1, 0, 1, 0, 1);
        // NaN anywhere, NaN with minus infinity flagged together
        send_beat(32'sh0001_0000, 0, 0, 0, 0);
        send_beat(-1, 1, 0, 0, 0);
        send_beat(0, 0, 0, 1, 1);
        send_beat(32'sh5555_AAAA, 1, 1, 0, 1);
        // filler beats without last do nothing; minus infinity adds nothing
        send_beat(-1, 1, 1, 1, 0);
        send_beat(32'sh0002_0000, 0, 0, 0, 0);
        send_beat(32'sh8000_0000, 0, 1, 0, 0);
        send_beat(-1, 0, 0, 1, 0);
        send_beat(32'sh0001_8000, 0, 0, 0, 1);

        // phases: free flow, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 8 : 0;
            stall_pct = (ph == 2) ? 48 : (ph == 3) ? 8 : 0;
            if (ph == 0)
            begin
                // overfill one set: elements past the limit are dropped,
                // including a NaN and a new maximum
                for (int i = 0; i < 1030; i++)
                    send_beat(i < 1024 ? near(0) : 32'sh7000_0000, i == 1027, 0, 0, 0);
                send_beat(0, 0, 0, 1, 1);
            end
            while (beats_sent < 21 + 1031 + 150 * (ph + 1))
                send_set($urandom_range(3) == 0 ? $urandom_range(40) : $urandom_range(6));
        end
        in_ch.valid <= 1'b0;

        // drain, then let the back end settle
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
